[hw/rtl/pal_pkg.sv]
// Shared types and constants for the positional array list.
// Used by pal_ctrl, pal_datapath and positional_array_list.
`default_nettype none

package pal_pkg;

	localparam int OP_W    = 3;
	localparam int VALUE_W = 32;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_GET    = 3'd2,
		OP_LOCATE = 3'd3,
		OP_CLEAR  = 3'd4
	} pal_op_t;

	// where the scan index starts
	typedef enum logic [1:0] {
		IDX_ZERO = 2'd0,
		IDX_POS  = 2'd1,
		IDX_TOP  = 2'd2
	} pal_idx_sel_t;

	// write address / data source
	typedef enum logic [1:0] {
		WR_UP  = 2'd0,
		WR_DN  = 2'd1,
		WR_NEW = 2'd2
	} pal_wr_sel_t;

	typedef struct packed {
		logic         latch;
		logic         idx_load;
		pal_idx_sel_t idx_sel;
		logic         rd_en;
		logic         dn;
		logic         wr_en;
		pal_wr_sel_t  wr_sel;
		logic         cap_val;
		logic         cap_found;
		logic         cnt_inc;
		logic         cnt_dec;
		logic         cnt_clr;
		logic         res_load;
		logic         res_ok;
	} pal_cmd_t;

	typedef struct packed {
		logic pos_ok;
		logic ins_ok;
		logic ins_at_end;
		logic cnt_zero;
		logic scan_at_pos;
		logic scan_at_top;
		logic rd_vld;
		logic rd_at_pos;
		logic match;
	} pal_sts_t;

endpackage

`default_nettype wire

[hw/rtl/pal_datapath.sv]
// Datapath of the positional array list: element memory, count, scan index,
// result registers. Sequenced by pal_ctrl; depends on pal_pkg.
`default_nettype none

module pal_datapath #(
	parameter int CAPACITY     = 64,
	parameter int ELEMENT_BITS = 32,
	parameter int POS_W        = 7
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [POS_W-1:0]                     position,
	input  logic signed [pal_pkg::VALUE_W-1:0]   value,
	input  pal_pkg::pal_cmd_t                    cmd,
	output pal_pkg::pal_sts_t                    sts,
	output logic                                 done,
	output logic                                 ok,
	output logic signed [pal_pkg::VALUE_W-1:0]   value_out,
	output logic [POS_W-1:0]                     found_position,
	output logic [POS_W-1:0]                     length,
	output logic                                 empty_res
);
	import pal_pkg::*;

	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [ELEMENT_BITS-1:0]        mem [CAPACITY];
	logic [POS_W-1:0]               pos_q;
	logic [ELEMENT_BITS-1:0]        word_q;
	logic [POS_W-1:0]               count_q;
	logic [ADDR_W-1:0]              idx_q;
	logic [ADDR_W-1:0]              rd_addr_q;
	logic                           rd_vld_q;
	logic [ELEMENT_BITS-1:0]        rd_data_q;
	logic signed [ELEMENT_BITS-1:0] val_q;
	logic [POS_W-1:0]               found_q;
	logic                           done_q;
	logic                           ok_q;
	logic signed [VALUE_W-1:0]      value_out_q;
	logic [POS_W-1:0]               found_out_q;
	logic [POS_W-1:0]               length_q;
	logic                           empty_q;

	logic [ADDR_W-1:0]       pos_idx;
	logic [ADDR_W-1:0]       top_idx;
	logic [ADDR_W-1:0]       wr_addr;
	logic [ELEMENT_BITS-1:0] wr_data;
	logic [POS_W:0]          count_p1;

	assign pos_idx  = ADDR_W'(pos_q - POS_W'(1));
	assign top_idx  = ADDR_W'(count_q - POS_W'(1));
	assign count_p1 = {1'b0, count_q} + (POS_W+1)'(1);

	assign sts.pos_ok      = (pos_q != '0) && (pos_q <= count_q);
	assign sts.ins_ok      = (pos_q != '0) && ({1'b0, pos_q} <= count_p1)
	                         && (count_q != POS_W'(CAPACITY));
	assign sts.ins_at_end  = ({1'b0, pos_q} == count_p1);
	assign sts.cnt_zero    = (count_q == '0);
	assign sts.scan_at_pos = (idx_q == pos_idx);
	assign sts.scan_at_top = (idx_q == top_idx);
	assign sts.rd_vld      = rd_vld_q;
	assign sts.rd_at_pos   = (rd_addr_q == pos_idx);
	assign sts.match       = (rd_data_q == word_q);

	always_comb begin
		wr_addr = rd_addr_q;
		wr_data = rd_data_q;
		unique case (cmd.wr_sel)
			WR_UP: begin
				wr_addr = rd_addr_q + ADDR_W'(1);
			end
			WR_DN: begin
				wr_addr = rd_addr_q - ADDR_W'(1);
			end
			WR_NEW: begin
				wr_addr = pos_idx;
				wr_data = word_q;
			end
			default: begin
				wr_addr = rd_addr_q;
			end
		endcase
	end

	// element store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[idx_q];
		end
	end

	// request and scan payload
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			pos_q  <= position;
			word_q <= ELEMENT_BITS'(value);
			val_q  <= '0;
			found_q <= '0;
		end else begin
			if (cmd.cap_val) begin
				val_q <= rd_data_q;
			end
			if (cmd.cap_found) begin
				found_q <= POS_W'(rd_addr_q) + POS_W'(1);
			end
		end
		if (cmd.idx_load) begin
			unique case (cmd.idx_sel)
				IDX_ZERO: idx_q <= '0;
				IDX_POS:  idx_q <= pos_idx;
				IDX_TOP:  idx_q <= top_idx;
				default:  idx_q <= '0;
			endcase
		end else if (cmd.rd_en) begin
			idx_q <= cmd.dn ? idx_q - ADDR_W'(1) : idx_q + ADDR_W'(1);
		end
		if (cmd.rd_en) begin
			rd_addr_q <= idx_q;
		end
		if (cmd.res_load) begin
			ok_q        <= cmd.res_ok;
			value_out_q <= VALUE_W'(val_q);
			found_out_q <= found_q;
			length_q    <= count_q;
			empty_q     <= (count_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_vld_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			rd_vld_q <= cmd.rd_en;
			done_q   <= cmd.res_load;
			if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + POS_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - POS_W'(1);
			end
		end
	end

	assign done           = done_q;
	assign ok             = ok_q;
	assign value_out      = value_out_q;
	assign found_position = found_out_q;
	assign length         = length_q;
	assign empty_res      = empty_q;

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + POS_W'(1))
		|| (count_q == $past(count_q) - POS_W'(1)) || (count_q == '0))
		else $error("count moved by more than one");

	a_wr_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (POS_W'(wr_addr) <= count_q))
		else $error("write beyond list tail");

	a_len_matches: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (length_q == count_q))
		else $error("reported length differs from count");

endmodule

`default_nettype wire

[hw/rtl/pal_ctrl.sv]
// Controller of the positional array list: decodes a request and steps the
// datapath through check, scan, shift and response. Depends on pal_pkg.
`default_nettype none

module pal_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pal_pkg::OP_W-1:0]      operation,
	input  pal_pkg::pal_sts_t             sts,
	output pal_pkg::pal_cmd_t             cmd,
	output logic                          busy
);
	import pal_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_DRAIN,
		S_WRITE_NEW,
		S_RESP
	} state_t;

	state_t            state_q, state_d;
	logic [OP_W-1:0]   op_q;
	logic              ok_q, ok_d;
	logic              busy_q;

	// handle the read that came back this cycle
	function automatic pal_cmd_t take_read(input pal_cmd_t c, input logic [OP_W-1:0] op,
	                                       input pal_sts_t s);
		pal_cmd_t r;
		r = c;
		case (op)
			OP_INSERT: begin
				r.wr_en  = s.rd_vld;
				r.wr_sel = WR_UP;
			end
			OP_DELETE: begin
				r.cap_val = s.rd_vld && s.rd_at_pos;
				r.wr_en   = s.rd_vld && !s.rd_at_pos;
				r.wr_sel  = WR_DN;
			end
			OP_GET: begin
				r.cap_val = s.rd_vld;
			end
			OP_LOCATE: begin
				r.cap_found = s.rd_vld && s.match;
			end
			default: begin
				r.wr_en = 1'b0;
			end
		endcase
		return r;
	endfunction

	always_comb begin
		state_d = state_q;
		ok_d    = ok_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_RESP;
				case (op_q)
					OP_INSERT: begin
						ok_d = sts.ins_ok;
						if (sts.ins_ok) begin
							if (sts.ins_at_end) begin
								state_d = S_WRITE_NEW;
							end else begin
								cmd.idx_load = 1'b1;
								cmd.idx_sel  = IDX_TOP;
								state_d      = S_SCAN;
							end
						end
					end
					OP_DELETE, OP_GET: begin
						ok_d = sts.pos_ok;
						if (sts.pos_ok) begin
							cmd.idx_load = 1'b1;
							cmd.idx_sel  = IDX_POS;
							state_d      = S_SCAN;
						end
					end
					OP_LOCATE: begin
						ok_d = 1'b1;
						if (!sts.cnt_zero) begin
							cmd.idx_load = 1'b1;
							cmd.idx_sel  = IDX_ZERO;
							state_d      = S_SCAN;
						end
					end
					OP_CLEAR: begin
						ok_d        = 1'b1;
						cmd.cnt_clr = 1'b1;
					end
					default: begin
						ok_d = 1'b0;
					end
				endcase
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				cmd.dn    = (op_q == OP_INSERT);
				cmd       = take_read(cmd, op_q, sts);
				// insert and get stop at the request position, delete at the tail, locate at the first match or the tail
				if (op_q == OP_LOCATE && sts.rd_vld && sts.match) begin
					state_d = S_RESP;
				end else if (((op_q == OP_INSERT) || (op_q == OP_GET)) ?
						sts.scan_at_pos : sts.scan_at_top) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				cmd     = take_read(cmd, op_q, sts);
				state_d = S_RESP;
				if (op_q == OP_INSERT) begin
					state_d = S_WRITE_NEW;
				end else if (op_q == OP_DELETE) begin
					cmd.cnt_dec = 1'b1;
				end
			end
			S_WRITE_NEW: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_NEW;
				cmd.cnt_inc = 1'b1;
				state_d     = S_RESP;
			end
			S_RESP: begin
				cmd.res_load = 1'b1;
				cmd.res_ok   = ok_q;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			ok_q    <= 1'b0;
			op_q    <= '0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
			ok_q    <= ok_d;
			if (cmd.latch) begin
				op_q <= operation;
			end
		end
	end

	assign busy = busy_q;

	a_resp_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> !busy_q)
		else $error("still busy after response");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (!cmd.wr_en && !cmd.rd_en && !cmd.cnt_inc && !cmd.cnt_dec))
		else $error("datapath activity while idle");

	a_busy_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(start))
		else $error("busy without an accepted request");

endmodule

`default_nettype wire

[hw/rtl/positional_array_list.sv]
// Positional array list, top level: ties pal_ctrl to pal_datapath.
// Depends on pal_pkg, pal_ctrl, pal_datapath.
`default_nettype none

// An ordered list of up to CAPACITY signed words held in a single-port-write,
// single-port-read memory, plus an element count. A request beat is taken on
// a clock edge with start high and busy low; busy then stays high until the
// response is registered. Exactly one result beat follows each request: done
// is high for one cycle with ok, value_out, found_position, length and
// empty_res valid, and the receiver cannot stall it, so capture it then.
// A new request may be issued in the same cycle that done shows.
// A request steps through decode, a scan that reads N entries through the
// memory read port, one per cycle, a drain step, a write of the new entry
// for an insert, and the response. Get reads 1, insert and delete read
// count - position + 1, locate reads up to one past the first match (all
// entries on a miss). Clear, an insert at the tail and any rejected request
// (bad position, full list, unknown code) skip the scan and the drain step.
// Shifting on insert and delete moves one entry per cycle, so the memory read
// port bounds the rate. Entries are never cleared: only entries below the
// count are ever read.

module positional_array_list #(
	parameter int CAPACITY     = 64,
	parameter int ELEMENT_BITS = 32,
	localparam int POS_W       = $clog2(CAPACITY + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [pal_pkg::OP_W-1:0]             operation,
	input  logic [POS_W-1:0]                     position,
	input  logic signed [pal_pkg::VALUE_W-1:0]   value,
	output logic                                 done,
	output logic                                 ok,
	output logic signed [pal_pkg::VALUE_W-1:0]   value_out,
	output logic [POS_W-1:0]                     found_position,
	output logic [POS_W-1:0]                     length,
	output logic                                 empty_res
);
	import pal_pkg::*;

	// command and status between the sequencer and the datapath
	pal_cmd_t cmd;
	pal_sts_t sts;

	pal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	pal_datapath #(
		.CAPACITY     (CAPACITY),
		.ELEMENT_BITS (ELEMENT_BITS),
		.POS_W        (POS_W)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.position       (position),
		.value          (value),
		.cmd            (cmd),
		.sts            (sts),
		.done           (done),
		.ok             (ok),
		.value_out      (value_out),
		.found_position (found_position),
		.length         (length),
		.empty_res      (empty_res)
	);

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for positional_array_list: random and directed list requests,
// with a request-level predictor of list contents and count. Depends on pal_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;

	import pal_pkg::*;

	localparam int LIST_DEPTH = 64;
	localparam int POS_W      = $clog2(LIST_DEPTH + 1);
	localparam int N_ITEMS    = 1100;
	localparam int DRAIN_CYC  = 100;    // idle margin after the last result beat
	localparam int MAX_REPORT = 100;

	// codes the block must ignore
	localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] word;
	} list_req_t;

	typedef struct packed {
		logic               ok;
		logic [VALUE_W-1:0] value_out;
		logic [POS_W-1:0]   found_position;
		logic [POS_W-1:0]   length;
		logic               empty_res;
	} list_result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [OP_W-1:0]           operation;
	logic [POS_W-1:0]          position;
	logic signed [VALUE_W-1:0] value;
	logic                      done;
	logic                      ok;
	logic signed [VALUE_W-1:0] value_out;
	logic [POS_W-1:0]          found_position;
	logic [POS_W-1:0]          length;
	logic                      empty_res;

	positional_array_list #(
		.CAPACITY     (LIST_DEPTH),
		.ELEMENT_BITS (VALUE_W)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.position       (position),
		.value          (value),
		.done           (done),
		.ok             (ok),
		.value_out      (value_out),
		.found_position (found_position),
		.length         (length),
		.empty_res      (empty_res)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// request beats waiting to be driven, and results owed by the block
	list_req_t    req_q[$];
	list_result_t owed_q[$];

	int n_queued;   // meaningful requests generated (ignored codes not counted)
	int n_pushed;   // all requests generated
	int n_sent;     // beats placed on the bus
	int n_taken;    // beats accepted by the block
	int n_fail;
	int gen_len;    // list length as seen by the generator, for aiming positions

	// predictor state
	logic [VALUE_W-1:0] shadow_mem [LIST_DEPTH];
	int                 shadow_len;

	// Apply one request to the shadow list and return the result it owes.
	function automatic list_result_t apply_request(input logic [OP_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic [VALUE_W-1:0] word);
		list_result_t r;
		int p;
		int j;
		r = '0;
		p = int'(pos);
		case (pal_op_t'(op))
			OP_INSERT: begin
				if (p >= 1 && p <= shadow_len + 1 && shadow_len < LIST_DEPTH) begin
					for (j = shadow_len; j > p - 1; j--)
						shadow_mem[j] = shadow_mem[j-1];
					shadow_mem[p-1] = word;
					shadow_len++;
					r.ok = 1'b1;
				end
			end
			OP_DELETE: begin
				if (p >= 1 && p <= shadow_len) begin
					r.value_out = shadow_mem[p-1];
					for (j = p - 1; j + 1 < shadow_len; j++)
						shadow_mem[j] = shadow_mem[j+1];
					shadow_len--;
					r.ok = 1'b1;
				end
			end
			OP_GET: begin
				if (p >= 1 && p <= shadow_len) begin
					r.value_out = shadow_mem[p-1];
					r.ok = 1'b1;
				end
			end
			OP_LOCATE: begin
				r.ok = 1'b1;
				for (j = 0; j < shadow_len; j++) begin
					if (r.found_position == '0 && shadow_mem[j] == word)
						r.found_position = POS_W'(j + 1);
				end
			end
			OP_CLEAR: begin
				shadow_len = 0;
				r.ok = 1'b1;
			end
			default: begin
				// unused code: no state change, ok stays low
			end
		endcase
		r.length    = POS_W'(shadow_len);
		r.empty_res = (shadow_len == 0);
		return r;
	endfunction

	// Queue one request; keep a rough length so random positions land mostly in range.
	task automatic push_request(input logic [OP_W-1:0] op, input int pos,
			input logic [VALUE_W-1:0] word);
		list_req_t rq;
		rq.op   = op;
		rq.pos  = POS_W'(pos);
		rq.word = word;
		req_q.push_back(rq);
		n_pushed++;
		if (op <= OP_CLEAR)
			n_queued++;
		case (op)
			OP_INSERT: if (pos >= 1 && pos <= gen_len + 1 && gen_len < LIST_DEPTH) gen_len++;
			OP_DELETE: if (pos >= 1 && pos <= gen_len) gen_len--;
			OP_CLEAR:  gen_len = 0;
			default:   ;
		endcase
	endtask

	// A small pool of values about half the time, so locate hits and duplicates occur.
	function automatic logic [VALUE_W-1:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return VALUE_W'($urandom_range(0, 7)) - VALUE_W'(4);
		if (r < 52)
			return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
		return $urandom();
	endfunction

	// Position: usually valid for the current length, sometimes anything in range.
	function automatic int pick_pos(input logic [OP_W-1:0] op);
		int hi;
		hi = (op == OP_INSERT) ? gen_len + 1 : gen_len;
		if (hi > LIST_DEPTH)
			hi = LIST_DEPTH;
		if (hi >= 1 && $urandom_range(0, 99) < 85)
			return $urandom_range(1, hi);
		return $urandom_range(0, LIST_DEPTH);
	endfunction

	// mode 0 grows the list, 1 shrinks it, 2 mixes, 3 fills it to capacity and pushes past
	task automatic push_random(input int mode);
		int ins_w;
		int del_w;
		int r;
		logic [OP_W-1:0] op;
		case (mode)
			0:       begin ins_w = 55; del_w = 10; end
			1:       begin ins_w = 10; del_w = 55; end
			3:       begin ins_w = (gen_len < LIST_DEPTH) ? 100 : 35; del_w = 0; end
			default: begin ins_w = 30; del_w = 25; end
		endcase
		r = $urandom_range(0, 99);
		if (r < ins_w)
			op = OP_INSERT;
		else if (r < ins_w + del_w)
			op = OP_DELETE;
		else if (r >= 97)
			op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		else if (r == 96 && mode != 3)
			op = OP_CLEAR;
		else
			op = $urandom_range(0, 1) ? OP_GET : OP_LOCATE;
		push_request(op, pick_pos(op), pick_word());
	endtask

	// Driver: one request beat per handshake; a beat holds while busy is high.
	// Random gaps with odds of about 9 in 100, none while a middle stretch of beats goes out.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			operation <= '0;
			position  <= '0;
			value     <= '0;
		end else if (!start || !busy) begin
			if (req_q.size() != 0 &&
					((n_sent >= 400 && n_sent < 650) || $urandom_range(0, 99) >= 9)) begin
				start     <= 1'b1;
				operation <= req_q[0].op;
				position  <= req_q[0].pos;
				value     <= req_q[0].word;
				req_q.delete(0);
				n_sent    <= n_sent + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic compare_field(input string fname, input logic [VALUE_W-1:0] want,
			input logic [VALUE_W-1:0] got);
		if (want !== got) begin
			if (n_fail < MAX_REPORT)
				$error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
			n_fail++;
		end
	endtask

	// Monitor: predict at each accepted request beat, check each result beat
	// against the oldest result still owed. The block can't stall results.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n) begin
			if (done) begin
				if (owed_q.size() == 0) begin
					if (n_fail < MAX_REPORT)
						$error("result beat with no request outstanding");
					n_fail++;
				end else begin
					want = owed_q.pop_front();
					compare_field("ok", VALUE_W'(want.ok), VALUE_W'(ok));
					compare_field("value_out", want.value_out, value_out);
					compare_field("found_position", VALUE_W'(want.found_position),
						VALUE_W'(found_position));
					compare_field("length", VALUE_W'(want.length), VALUE_W'(length));
					compare_field("empty_res", VALUE_W'(want.empty_res), VALUE_W'(empty_res));
				end
			end
			if (start && !busy) begin
				owed_q.push_back(apply_request(operation, position, value));
				n_taken++;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int mode;
		int burst;
		n_queued   = 0;
		n_pushed   = 0;
		n_sent     = 0;
		n_taken    = 0;
		n_fail     = 0;
		gen_len    = 0;
		shadow_len = 0;
		arst_n     = 1'b0;

		// directed: empty-list rejects, edges of position, extremes of value
		push_request(OP_GET, 1, 32'd0);              // read from empty list
		push_request(OP_DELETE, 0, 32'd0);           // position zero
		push_request(OP_LOCATE, 0, 32'd0);           // search empty list
		push_request(OP_INSERT, 0, 32'd5);           // position zero
		push_request(OP_INSERT, 2, 32'd5);           // past the tail
		push_request(OP_INSERT, 1, 32'h7fff_ffff);   // first entry, max value
		push_request(OP_INSERT, 1, 32'h8000_0000);   // head, min value
		push_request(OP_INSERT, 3, 32'd0);           // tail
		push_request(OP_INSERT, 2, 32'hffff_ffff);   // middle
		push_request(OP_GET, 1, 32'd0);
		push_request(OP_GET, 4, 32'd0);
		push_request(OP_GET, 5, 32'd0);              // one past count
		push_request(OP_GET, LIST_DEPTH, 32'd0);     // top position, out of range
		push_request(OP_LOCATE, 0, 32'hffff_ffff);
		push_request(OP_LOCATE, 0, 32'h7fff_ffff);
		push_request(OP_LOCATE, 0, 32'd123);         // miss
		push_request(OP_INSERT, 2, 32'd0);           // duplicate: first match wins
		push_request(OP_LOCATE, 0, 32'd0);
		push_request(OP_DELETE, 5, 32'd0);           // tail
		push_request(OP_DELETE, 1, 32'd0);           // head
		push_request(OP_DELETE, 4, 32'd0);           // past count
		push_request(OP_UNUSED_LO, 1, 32'd1);
		push_request(OP_UNUSED_HI, LIST_DEPTH, 32'hffff_ffff);
		push_request(OP_CLEAR, 0, 32'd0);
		push_request(OP_DELETE, 1, 32'd0);           // delete after clear
		push_request(OP_UNUSED_MID, 0, 32'd0);

		// random bursts, each biased toward one behavior
		while (n_queued < N_ITEMS) begin
			mode  = $urandom_range(0, 3);
			burst = $urandom_range(30, 90);
			repeat (burst) push_random(mode);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (n_taken < n_pushed)
			@(posedge clk);
		while (owed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (n_fail == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: ends the run as a failure if it hangs.
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule

[files.f]
hw/rtl/pal_pkg.sv
hw/rtl/pal_datapath.sv
hw/rtl/pal_ctrl.sv
hw/rtl/positional_array_list.sv
dv/tb_top.sv
